// File: src/asev_pkg.sv
package asev_pkg;

  localparam int MAX_TARGETS = 64;
  localparam int FRAC_BITS   = 16;

  localparam int IDX_W    = $clog2(MAX_TARGETS);
  localparam int CNT_W    = 7;
  localparam int OPC_W    = 2;
  localparam int THREAT_W = 16;
  localparam int PROB_W   = FRAC_BITS + 1;
  localparam int SURV_W   = FRAC_BITS + 1;
  localparam int MUL_W    = 2 * SURV_W;
  localparam int EPROD_W  = THREAT_W + SURV_W;
  localparam int TOT_W    = THREAT_W + IDX_W;
  localparam int SUM_W    = 38;

  localparam logic [SURV_W-1:0] SURV_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_TARGETS);
  localparam logic [CNT_W-1:0]  CNT_RST  = CNT_W'(64);

  localparam logic [OPC_W-1:0] OPC_LOAD  = 2'd0;
  localparam logic [OPC_W-1:0] OPC_APPLY = 2'd1;
  localparam logic [OPC_W-1:0] OPC_EVAL  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [5:0]          target_index;
    logic [THREAT_W-1:0] threat_value;
    logic [PROB_W-1:0]   kill_prob;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [SUM_W-1:0] remaining_threat;
    logic [SUM_W-1:0] destroyed_threat;
  } out_item_t;

  typedef enum logic [1:0] {
    TOK_LOAD  = 2'd0,
    TOK_APPLY = 2'd1,
    TOK_EVAL  = 2'd2,
    TOK_ERR   = 2'd3
  } tok_op_t;

  // Item as it travels down the chain, with the running sums of an evaluate
  typedef struct packed {
    logic                valid;
    tok_op_t             op;
    logic [IDX_W-1:0]    idx;
    logic [THREAT_W-1:0] threat;
    logic [SURV_W-1:0]   factor;
    logic [SUM_W-1:0]    rem;
    logic [TOT_W-1:0]    tot;
    logic [EPROD_W-1:0]  prod;
  } token_t;

endpackage

// File: src/assignment_survival_evaluator_core.sv
// An evaluate or error item reaches its result at the output register through the
// entry stage, one stage per target cell over 64 cells, a summing stage and output.
// Throughput: one item per cycle for load, apply and evaluate alike; the whole
// chain advances together and holds while a result waits unclaimed.
// Reset (synchronous, rst_n low): clear all valid flags, set every survival to
// 1.0 and target_count to 64; threat values stay undefined until loaded.
module assignment_survival_evaluator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  asev_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output asev_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [asev_pkg::CNT_W-1:0]  cfg_wdata
);
  import asev_pkg::*;

  logic [CNT_W-1:0] tcount_r;
  logic [CNT_W-1:0] n_eff;
  logic             advance;
  logic             idx_ok;
  logic             op_known;
  token_t           entry_r, entry_nxt;
  token_t           chain [MAX_TARGETS+1];

  // Advance the whole row whenever the output register is free or being taken.
  // A stalled result holds every stage, so input is stalled with it.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Clamp the count: zero acts as one, anything past the row acts as the full row
  always_comb begin
    if (tcount_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (tcount_r > CNT_MAX) begin
      n_eff = CNT_MAX;
    end else begin
      n_eff = tcount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcount_r <= CNT_RST;
    end else if (cfg_we) begin
      tcount_r <= cfg_wdata;
    end
  end

  // Entry stage: decode the opcode, check the index, saturate the probability
  // and turn it into the survival factor (1.0 - p). An unknown opcode makes no
  // item at all; a bad index travels as an error item so results keep order.
  assign idx_ok   = (CNT_W'(in_data.target_index) < n_eff);
  assign op_known = in_data.opcode inside {OPC_LOAD, OPC_APPLY, OPC_EVAL};

  always_comb begin
    entry_nxt        = '0;
    entry_nxt.valid  = in_valid && op_known;
    entry_nxt.idx    = IDX_W'(in_data.target_index);
    entry_nxt.threat = in_data.threat_value;
    entry_nxt.factor = (in_data.kill_prob > PROB_W'(SURV_ONE)) ? '0
                       : (SURV_ONE - SURV_W'(in_data.kill_prob));
    case (in_data.opcode)
      OPC_LOAD:  entry_nxt.op = idx_ok ? TOK_LOAD : TOK_ERR;
      OPC_APPLY: entry_nxt.op = idx_ok ? TOK_APPLY : TOK_ERR;
      OPC_EVAL:  entry_nxt.op = TOK_EVAL;
      default:   entry_nxt.op = TOK_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (advance) begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_r.op     <= entry_nxt.op;
      entry_r.idx    <= entry_nxt.idx;
      entry_r.threat <= entry_nxt.threat;
      entry_r.factor <= entry_nxt.factor;
      entry_r.rem    <= entry_nxt.rem;
      entry_r.tot    <= entry_nxt.tot;
      entry_r.prod   <= entry_nxt.prod;
    end
  end

  assign chain[0] = entry_r;

  // One cell per target: each keeps that target's threat and survival, acts on
  // items addressed to it, and on an evaluate adds its share to the running sums
  // before handing the item on to its neighbour.
  for (genvar g = 0; g < MAX_TARGETS; g++) begin : g_cell
    asev_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (IDX_W'(g)),
      .n_eff    (n_eff),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  // Finish the sums, form destroyed threat and hold the result for the consumer
  asev_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .tok_in    (chain[MAX_TARGETS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: src/asev_cell.sv
module asev_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [asev_pkg::IDX_W-1:0]   cell_idx,
  input  logic [asev_pkg::CNT_W-1:0]   n_eff,
  input  asev_pkg::token_t             tok_in,
  output asev_pkg::token_t             tok_out
);
  import asev_pkg::*;

  logic [THREAT_W-1:0] threat_r, threat_nxt;
  logic [SURV_W-1:0]   surv_r, surv_nxt;
  token_t              tok_r, tok_nxt;
  logic                hit;
  logic                counted;
  logic [SURV_W-1:0]   mul_b;
  logic [MUL_W-1:0]    product;

  assign hit     = tok_in.valid && (tok_in.idx == cell_idx);
  assign counted = ({1'b0, cell_idx} < n_eff);

  // One multiplier: survival update on apply, threat times survival on evaluate
  assign mul_b   = (tok_in.op == TOK_APPLY) ? tok_in.factor : {1'b0, threat_r};
  assign product = MUL_W'(surv_r) * MUL_W'(mul_b);

  always_comb begin
    threat_nxt = threat_r;
    surv_nxt   = surv_r;
    tok_nxt    = tok_in;
    if (tok_in.valid) begin
      case (tok_in.op)
        TOK_LOAD: begin
          if (hit) begin
            threat_nxt = tok_in.threat;
          end
        end
        TOK_APPLY: begin
          if (hit) begin
            surv_nxt = product[FRAC_BITS +: SURV_W];
          end
        end
        TOK_EVAL: begin
          surv_nxt     = SURV_ONE;
          tok_nxt.rem  = tok_in.rem + SUM_W'(tok_in.prod);
          tok_nxt.prod = counted ? product[EPROD_W-1:0] : '0;
          tok_nxt.tot  = tok_in.tot + (counted ? TOT_W'(threat_r) : '0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surv_r      <= SURV_ONE;
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      surv_r      <= surv_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      threat_r     <= threat_nxt;
      tok_r.op     <= tok_nxt.op;
      tok_r.idx    <= tok_nxt.idx;
      tok_r.threat <= tok_nxt.threat;
      tok_r.factor <= tok_nxt.factor;
      tok_r.rem    <= tok_nxt.rem;
      tok_r.tot    <= tok_nxt.tot;
      tok_r.prod   <= tok_nxt.prod;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: src/asev_tail.sv
module asev_tail (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  asev_pkg::token_t      tok_in,
  output logic                  out_valid,
  output asev_pkg::out_item_t   out_data
);
  import asev_pkg::*;

  logic             tail_valid_r, tail_valid_nxt;
  logic             tail_err_r, tail_err_nxt;
  logic [SUM_W-1:0] tail_rem_r, tail_rem_nxt;
  logic [TOT_W-1:0] tail_tot_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [SUM_W-1:0] total_fix;

  // Fold in the product still pending from the last cell
  assign tail_valid_nxt = tok_in.valid && (tok_in.op inside {TOK_EVAL, TOK_ERR});
  assign tail_err_nxt   = (tok_in.op == TOK_ERR);
  assign tail_rem_nxt   = tok_in.rem + SUM_W'(tok_in.prod);

  assign total_fix     = SUM_W'({tail_tot_r, {FRAC_BITS{1'b0}}});
  assign out_valid_nxt = tail_valid_r;

  always_comb begin
    out_data_nxt.status           = tail_err_r;
    out_data_nxt.remaining_threat = tail_err_r ? '0 : tail_rem_r;
    out_data_nxt.destroyed_threat = tail_err_r ? '0 : (total_fix - tail_rem_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      tail_valid_r <= tail_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tail_err_r <= tail_err_nxt;
      tail_rem_r <= tail_rem_nxt;
      tail_tot_r <= tok_in.tot;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/asev_checker.sv
module asev_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input asev_pkg::out_item_t  out_data
);
  import asev_pkg::*;

  // A result held back must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

  // A waiting result must back-pressure the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while a result is stuck");

  // Nothing is offered straight after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // An error result carries no sums
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
      (out_data.remaining_threat == '0 && out_data.destroyed_threat == '0))
    else $error("error result with non-zero sums");

endmodule

bind assignment_survival_evaluator_core asev_checker u_asev_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/tb.sv
module tb;
  import asev_pkg::*;

  // Items must cross the whole chain; allow a margin beyond that before idling is
  // trusted
  localparam int SETTLE_CYCLES = 90;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_WAIT      = 17;
  localparam int PHASE_ITEMS   = 215;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Opcode with no meaning: the block drops it
  localparam logic [OPC_W-1:0] OPC_SKIP = 2'd3;

  // Scoreboard: own copy of the threat and survival tables and of target_count,
  // plus the queue of reports the block still owes us.
  class survival_ledger;
    logic [THREAT_W-1:0] threat_q [MAX_TARGETS];
    logic [SURV_W-1:0]   surv_q   [MAX_TARGETS];
    bit                  loaded   [MAX_TARGETS];
    logic [CNT_W-1:0]    count_reg;
    out_item_t           awaited_reports [$];
    int unsigned         fails;

    function new();
      count_reg = CNT_RST;
      fails = 0;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        surv_q[i] = SURV_ONE;
        loaded[i] = 1'b0;
      end
    endfunction

    function void write_count(logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    // Targets in use: zero counts as one, anything past the table as the table
    function int unsigned span();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_TARGETS) return MAX_TARGETS;
      return count_reg;
    endfunction

    function bit ready_to_evaluate();
      for (int i = 0; i < span(); i++)
        if (!loaded[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned first_unloaded();
      for (int i = 0; i < span(); i++)
        if (!loaded[i]) return i;
      return 0;
    endfunction

    function void note_item(in_item_t it);
      int unsigned         n;
      int unsigned         idx;
      logic [SURV_W-1:0]   p;
      logic [MUL_W-1:0]    prod;
      logic [SUM_W-1:0]    rem;
      logic [SUM_W-1:0]    tot;
      out_item_t           rpt;
      n = span();
      idx = it.target_index;
      rpt = '0;
      case (it.opcode)
        OPC_LOAD, OPC_APPLY: begin
          if (idx >= n) begin
            // out of range: error report, tables untouched
            rpt.status = STATUS_RANGE;
            awaited_reports.push_back(rpt);
          end else if (it.opcode == OPC_LOAD) begin
            threat_q[idx] = it.threat_value;
            loaded[idx] = 1'b1;
          end else begin
            p = (it.kill_prob > SURV_ONE) ? SURV_ONE : it.kill_prob;
            prod = MUL_W'(surv_q[idx]) * MUL_W'(SURV_ONE - p);
            surv_q[idx] = SURV_W'(prod >> FRAC_BITS);
          end
        end
        OPC_EVAL: begin
          rem = '0;
          tot = '0;
          for (int i = 0; i < n; i++) begin
            tot += SUM_W'(threat_q[i]) << FRAC_BITS;
            rem += SUM_W'(threat_q[i]) * SUM_W'(surv_q[i]);
          end
          // every entry returns to 1.0, counted or not
          for (int i = 0; i < MAX_TARGETS; i++) surv_q[i] = SURV_ONE;
          rpt.status = STATUS_DONE;
          rpt.remaining_threat = rem;
          rpt.destroyed_threat = tot - rem;
          awaited_reports.push_back(rpt);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_reports.size() == 0) begin
        $error("unexpected report: status %0d remaining %0d destroyed %0d",
               got.status, got.remaining_threat, got.destroyed_threat);
        fails++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.remaining_threat !== want.remaining_threat) begin
        $error("remaining_threat: expected %0d, got %0d",
               want.remaining_threat, got.remaining_threat);
        fails++;
      end
      if (got.destroyed_threat !== want.destroyed_threat) begin
        $error("destroyed_threat: expected %0d, got %0d",
               want.destroyed_threat, got.destroyed_threat);
        fails++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_item_t         in_data   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_stall;
  logic             out_valid;
  out_item_t        out_data;

  survival_ledger ledger = new();
  int unsigned    cycles = 0;
  int             send_calm = 0;
  int             sink_calm = 0;

  assignment_survival_evaluator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Draw an idle count per item; now and then run a stretch with no idling at all
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic in_item_t make_item(logic [OPC_W-1:0] op, int unsigned idx,
                                         int unsigned thr, int unsigned prob);
    in_item_t it;
    it.opcode       = op;
    it.target_index = 6'(idx);
    it.threat_value = THREAT_W'(thr);
    it.kill_prob    = PROB_W'(prob);
    return it;
  endfunction

  function automatic int unsigned rand_threat();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Lean towards small kill probabilities so that survival compounds over
  // several attackers before it collapses to zero
  function automatic int unsigned rand_prob();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return SURV_ONE;
      2:       return $urandom_range(SURV_ONE + 1, (1 << PROB_W) - 1);
      3, 4, 5: return $urandom_range(0, 4095);
      default: return $urandom_range(0, SURV_ONE);
    endcase
  endfunction

  // Present one item after a random gap, hold it until taken, then tell the ledger
  task automatic push_item(input in_item_t it);
    int gap;
    gap = draw_wait(send_calm);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_item(it);
  endtask

  // Drop valid, wait for every owed report, then let the chain empty of
  // loads and applies that produce nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic set_target_count(input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.write_count(v);
  endtask

  // An evaluate must never read a threat that was never loaded
  task automatic fill_unloaded(inout int sent);
    while (!ledger.ready_to_evaluate()) begin
      push_item(make_item(OPC_LOAD, ledger.first_unloaded(), rand_threat(), $urandom));
      sent++;
    end
  endtask

  task automatic random_phase(input int budget);
    int          sent;
    int unsigned n;
    int          k;
    bit          paused;
    sent = 0;
    paused = 1'b0;
    while (sent < budget) begin
      n = ledger.span();
      if ($urandom_range(0, 99) < 85) begin
        // well-formed round: a few loads, several attackers, then evaluate
        k = $urandom_range(0, 3);
        repeat (k) begin
          push_item(make_item(OPC_LOAD, $urandom_range(0, n - 1), rand_threat(), $urandom));
          sent++;
        end
        k = $urandom_range(1, 8);
        repeat (k) begin
          push_item(make_item(OPC_APPLY,
                              ($urandom_range(0, 1) == 0) ? $urandom_range(0, (n < 4 ? n : 4) - 1)
                                                          : $urandom_range(0, n - 1),
                              $urandom, rand_prob()));
          sent++;
        end
        fill_unloaded(sent);
        push_item(make_item(OPC_EVAL, $urandom, $urandom, $urandom));
        sent++;
      end else begin
        // noise: ignored opcode, out-of-range index, stray evaluate or apply
        case ($urandom_range(0, 3))
          0: push_item(make_item(OPC_SKIP, $urandom, $urandom, $urandom));
          1: begin
            if (n < MAX_TARGETS)
              push_item(make_item($urandom_range(0, 1) ? OPC_APPLY : OPC_LOAD,
                                  $urandom_range(n, MAX_TARGETS - 1), rand_threat(), rand_prob()));
            else
              push_item(make_item(OPC_LOAD, $urandom_range(0, n - 1), rand_threat(), $urandom));
            sent++;
          end
          2: begin
            fill_unloaded(sent);
            push_item(make_item(OPC_EVAL, $urandom, $urandom, $urandom));
            sent++;
          end
          default: begin
            push_item(make_item(OPC_APPLY, $urandom_range(0, n - 1), $urandom, rand_prob()));
            sent++;
          end
        endcase
      end
      // hold the sender once per phase until everything owed has come back
      if (!paused && sent >= budget / 2) begin
        settle();
        paused = 1'b1;
      end
    end
    settle();
  endtask

  // Receiver: stall a random number of cycles ahead of each report
  initial begin : report_sink
    int hold;
    @(posedge clk);
    forever begin
      hold = draw_wait(sink_calm);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      ledger.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int          dummy;
    logic [CNT_W-1:0] counts [8];
    dummy = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two targets, extremes of threat and probability, saturation,
    // out-of-range on both opcodes, the ignored opcode, repeat evaluate
    set_target_count(CNT_W'(2));
    push_item(make_item(OPC_LOAD, 0, 16'hFFFF, 0));
    push_item(make_item(OPC_LOAD, 1, 0, (1 << PROB_W) - 1));
    push_item(make_item(OPC_APPLY, 0, 0, 0));
    push_item(make_item(OPC_EVAL, 0, 0, 0));
    push_item(make_item(OPC_APPLY, 0, 16'hFFFF, SURV_ONE));
    push_item(make_item(OPC_APPLY, 1, 0, (1 << PROB_W) - 1));
    push_item(make_item(OPC_EVAL, 63, 16'hFFFF, (1 << PROB_W) - 1));
    push_item(make_item(OPC_LOAD, 2, 16'hFFFF, 0));
    push_item(make_item(OPC_APPLY, 63, 0, 1));
    push_item(make_item(OPC_SKIP, 63, 16'hFFFF, (1 << PROB_W) - 1));
    push_item(make_item(OPC_LOAD, 1, 12345, 0));
    push_item(make_item(OPC_APPLY, 1, 0, 1));
    push_item(make_item(OPC_APPLY, 0, 0, SURV_ONE / 2));
    push_item(make_item(OPC_APPLY, 0, 0, SURV_ONE / 2));
    push_item(make_item(OPC_EVAL, 0, 0, 0));
    push_item(make_item(OPC_EVAL, 0, 0, 0));
    settle();

    // Random phases over several counts, extremes and out-of-table values included
    counts[0] = CNT_W'(1);
    counts[1] = CNT_MAX;
    counts[2] = CNT_W'(0);
    counts[3] = CNT_W'(127);
    counts[4] = CNT_W'(65);
    counts[5] = CNT_W'(3);
    counts[6] = CNT_W'($urandom_range(1, MAX_TARGETS));
    counts[7] = CNT_W'($urandom_range(0, 127));
    foreach (counts[i]) begin
      set_target_count(counts[i]);
      random_phase(PHASE_ITEMS);
    end

    // Evaluate with a short count must still restore survival past the count
    set_target_count(CNT_MAX);
    fill_unloaded(dummy);
    push_item(make_item(OPC_APPLY, 50, 0, SURV_ONE));
    push_item(make_item(OPC_APPLY, 63, 0, 1000));
    settle();
    set_target_count(CNT_W'(3));
    push_item(make_item(OPC_EVAL, 0, 0, 0));
    settle();
    set_target_count(CNT_MAX);
    push_item(make_item(OPC_EVAL, 0, 0, 0));
    settle();

    if (ledger.fails == 0 && ledger.awaited_reports.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
